/* rtl/hsv_to_rgb_converter_defines.svh */
// Assertion macros shared by the HSV to RGB converter RTL.
// Depends on nothing; each file that asserts includes this header.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is asserted.
`define HTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked assertion that is also checked during reset.
`define HTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HTR_ASSERT(lbl, clk, rst_n, prop, msg)
`define HTR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/htr_pkg.sv */
// Shared constants and types for the HSV to RGB converter.
// No dependencies; every RTL module imports this package.
package htr_pkg;

  // Field widths.
  localparam int IN_W  = 16;
  localparam int CH_W  = 8;
  localparam int HUE_W = 9;
  localparam int NUM_W = 22;

  // Color-space constants.
  localparam int HUE_CIRCLE = 360;
  localparam int FULL_SCALE = 255;
  localparam int SECTOR_DEG = 60;
  localparam int DENOM      = FULL_SCALE * SECTOR_DEG;

  // Hue wrap: bias the signed hue by a multiple of the circle, then divide
  // by reciprocal multiplication with one correction step.
  localparam int HUE_OFFSET      = ((32768 + HUE_CIRCLE - 1) / HUE_CIRCLE) * HUE_CIRCLE;
  localparam int HUE_RECIP_SHIFT = 24;
  localparam int HUE_RECIP       = (1 << HUE_RECIP_SHIFT) / HUE_CIRCLE;

  // Channel divide by DENOM, same scheme.
  localparam int DIV_RECIP_SHIFT = 32;
  localparam longint DIV_RECIP   = (64'd1 << DIV_RECIP_SHIFT) / DENOM;
  localparam int DIV_RECIP_W     = 19;

  // Pipeline depth from start to result strobe.
  localparam int LATENCY = 7;

  // Hue sectors of 60 degrees.
  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  // Wrapped hue with clamped saturation and value.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_norm_t;

  // Chroma, ramp and offset terms scaled by DENOM.
  typedef struct packed {
    sector_t          sector;
    logic [NUM_W-1:0] chroma;
    logic [NUM_W-1:0] ramp;
    logic [NUM_W-1:0] offset;
  } chroma_terms_t;

endpackage

/* rtl/htr_hue_wrap.sv */
// Two-stage hue wrap modulo 360 and saturation/value clamp.
// Depends on htr_pkg and the converter defines header.
`include "hsv_to_rgb_converter_defines.svh"

module htr_hue_wrap (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  input  logic signed [htr_pkg::IN_W-1:0]  hue_i,
  input  logic signed [htr_pkg::IN_W-1:0]  sat_i,
  input  logic signed [htr_pkg::IN_W-1:0]  val_i,
  output logic                             valid_o,
  output htr_pkg::hsv_norm_t               pix_o
);
  import htr_pkg::*;

  localparam int Q_W = 8;

  logic                 vld1_r, vld2_r;
  logic [IN_W:0]        hoff_r, hoff_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;
  logic [CH_W-1:0]      sat1_r, sat1_nxt, val1_r, val1_nxt;
  hsv_norm_t            pix_r, pix_nxt;
  logic [IN_W:0]        hsum;
  logic [2*IN_W:0]      hprod;
  logic [IN_W:0]        hrem;

  // Clamp a signed field to 0..255.
  function automatic logic [CH_W-1:0] clamp_byte(input logic signed [IN_W-1:0] v);
    logic [CH_W-1:0] res;
    if (v[IN_W-1]) begin
      res = '0;
    end else if (v[IN_W-2:CH_W] != '0) begin
      res = CH_W'(FULL_SCALE);
    end else begin
      res = v[CH_W-1:0];
    end
    return res;
  endfunction

  // Stage 1: bias hue to non-negative and estimate the quotient by 360.
  // The bias covers the most negative hue, so the sum needs one extra bit.
  always_comb begin
    hsum     = {hue_i[IN_W-1], hue_i} + (IN_W+1)'(HUE_OFFSET);
    hoff_nxt = hsum;
    hprod    = hoff_nxt * IN_W'(HUE_RECIP);
    q_nxt    = hprod[HUE_RECIP_SHIFT +: Q_W];
    sat1_nxt = clamp_byte(sat_i);
    val1_nxt = clamp_byte(val_i);
  end

  // Stage 2: remainder with one correction step.
  always_comb begin
    hrem = hoff_r - (IN_W+1)'(q_r) * (IN_W+1)'(HUE_CIRCLE);
    if (hrem >= (IN_W+1)'(HUE_CIRCLE)) begin
      hrem = hrem - (IN_W+1)'(HUE_CIRCLE);
    end
    pix_nxt.hue = hrem[HUE_W-1:0];
    pix_nxt.sat = sat1_r;
    pix_nxt.val = val1_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hoff_r <= hoff_nxt;
    q_r    <= q_nxt;
    sat1_r <= sat1_nxt;
    val1_r <= val1_nxt;
    pix_r  <= pix_nxt;
  end

  assign valid_o = vld2_r;
  assign pix_o   = pix_r;

  `HTR_ASSERT(a_hue_wrapped, clk, rst_n, vld1_r |=> (pix_r.hue < HUE_W'(HUE_CIRCLE)), "hue out of range")

endmodule

/* rtl/htr_chroma.sv */
// Two-stage chroma, ramp and offset computation scaled by 255*60.
// Depends on htr_pkg and the converter defines header.
`include "hsv_to_rgb_converter_defines.svh"

module htr_chroma (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  htr_pkg::hsv_norm_t    pix_i,
  output logic                  valid_o,
  output htr_pkg::chroma_terms_t terms_o
);
  import htr_pkg::*;

  localparam int W_W  = 6;
  localparam int VS_W = 2 * CH_W;

  logic              vld1_r, vld2_r;
  sector_t           sec_r, sec_nxt;
  logic [W_W-1:0]    w_r, w_nxt;
  logic [VS_W-1:0]   vs_r, vs_nxt;
  logic [CH_W-1:0]   val_r;
  logic [HUE_W-1:0]  hm, hdist;
  chroma_terms_t     terms_r, terms_nxt;

  // Stage 1: sector, ramp weight 60-|H mod 120 - 60| and V*S.
  always_comb begin
    if (pix_i.hue >= HUE_W'(300)) begin
      sec_nxt = SEC_M_TO_R;
    end else if (pix_i.hue >= HUE_W'(240)) begin
      sec_nxt = SEC_B_TO_M;
    end else if (pix_i.hue >= HUE_W'(180)) begin
      sec_nxt = SEC_C_TO_B;
    end else if (pix_i.hue >= HUE_W'(120)) begin
      sec_nxt = SEC_G_TO_C;
    end else if (pix_i.hue >= HUE_W'(SECTOR_DEG)) begin
      sec_nxt = SEC_Y_TO_G;
    end else begin
      sec_nxt = SEC_R_TO_Y;
    end
    if (pix_i.hue >= HUE_W'(240)) begin
      hm = pix_i.hue - HUE_W'(240);
    end else if (pix_i.hue >= HUE_W'(120)) begin
      hm = pix_i.hue - HUE_W'(120);
    end else begin
      hm = pix_i.hue;
    end
    if (hm >= HUE_W'(SECTOR_DEG)) begin
      hdist = hm - HUE_W'(SECTOR_DEG);
    end else begin
      hdist = HUE_W'(SECTOR_DEG) - hm;
    end
    w_nxt  = W_W'(HUE_W'(SECTOR_DEG) - hdist);
    vs_nxt = pix_i.sat * pix_i.val;
  end

  // Stage 2: scaled chroma, ramp and offset.
  always_comb begin
    terms_nxt.sector = sec_r;
    terms_nxt.chroma = NUM_W'(vs_r) * NUM_W'(SECTOR_DEG);
    terms_nxt.ramp   = NUM_W'(vs_r) * NUM_W'(w_r);
    terms_nxt.offset = NUM_W'(val_r) * NUM_W'(DENOM) - terms_nxt.chroma;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;
    w_r     <= w_nxt;
    vs_r    <= vs_nxt;
    val_r   <= pix_i.val;
    terms_r <= terms_nxt;
  end

  assign valid_o = vld2_r;
  assign terms_o = terms_r;

  `HTR_ASSERT(a_ramp_le_chroma, clk, rst_n, vld2_r |-> (terms_r.ramp <= terms_r.chroma), "ramp above chroma")

endmodule

/* rtl/htr_div_denom.sv */
// Two-stage divide of a scaled channel sum by 255*60.
// Depends on htr_pkg and the converter defines header.
`include "hsv_to_rgb_converter_defines.svh"

module htr_div_denom (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [htr_pkg::NUM_W-1:0]   num_i,
  output logic                        valid_o,
  output logic [htr_pkg::CH_W-1:0]    quot_o
);
  import htr_pkg::*;

  localparam int PROD_W = NUM_W + DIV_RECIP_W;

  logic              vld1_r, vld2_r;
  logic [NUM_W-1:0]  num_r;
  logic [CH_W-1:0]   qest_r, qest_nxt;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  rem;
  logic [CH_W-1:0]   quot_r, quot_nxt;

  // Stage 1: quotient estimate, at most one below the true quotient.
  always_comb begin
    prod     = num_i * DIV_RECIP_W'(DIV_RECIP);
    qest_nxt = prod[DIV_RECIP_SHIFT +: CH_W];
  end

  // Stage 2: remainder check and correction.
  always_comb begin
    rem = num_r - NUM_W'(qest_r) * NUM_W'(DENOM);
    if (rem >= NUM_W'(DENOM)) begin
      quot_nxt = qest_r + CH_W'(1);
    end else begin
      quot_nxt = qest_r;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= valid_i;
      vld2_r <= vld1_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    num_r  <= num_i;
    qest_r <= qest_nxt;
    quot_r <= quot_nxt;
  end

  assign valid_o = vld2_r;
  assign quot_o  = quot_r;

  `HTR_ASSERT(a_one_correction, clk, rst_n, vld1_r |-> (rem < NUM_W'(2 * DENOM)), "estimate off by two")

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// Top level of the pipelined HSV to RGB pixel converter.
// Depends on htr_pkg, htr_hue_wrap, htr_chroma, htr_div_denom and the defines header.
//
// Usage:
//   A pixel transaction is taken at a rising edge with start high and busy low.
//   busy is always low: the pipeline takes one pixel in every clock cycle.
//   in_hue is any signed angle, wrapped modulo 360; in_saturation and
//   in_brightness are clamped to 0..255.
//   Each result appears on out_red, out_green and out_blue for exactly one
//   cycle with out_valid high. Throughput is one pixel per cycle; the
//   pipeline holds seven register stages: two for the hue wrap (reciprocal
//   multiply, then correction), two for chroma and ramp, one for channel
//   selection and the offset add, and two for the divide by 255*60.
//   The receiver cannot stall; results are not held.
//   Synchronous reset clears all valid bits, so no result is issued for
//   transactions in flight when reset is asserted.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [htr_pkg::IN_W-1:0]  in_hue,
  input  logic signed [htr_pkg::IN_W-1:0]  in_saturation,
  input  logic signed [htr_pkg::IN_W-1:0]  in_brightness,
  output logic                             out_valid,
  output logic [htr_pkg::CH_W-1:0]         out_red,
  output logic [htr_pkg::CH_W-1:0]         out_green,
  output logic [htr_pkg::CH_W-1:0]         out_blue
);
  import htr_pkg::*;

  logic             in_accept;
  logic             wrap_vld, chr_vld, sum_vld_r;
  hsv_norm_t        wrap_pix;
  chroma_terms_t    terms;
  logic [NUM_W-1:0] r_term, g_term, b_term;
  logic [NUM_W-1:0] r_sum_r, g_sum_r, b_sum_r;
  logic [NUM_W-1:0] r_sum_nxt, g_sum_nxt, b_sum_nxt;
  logic             r_vld, g_vld, b_vld;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Hue wrap and clamp.
  htr_hue_wrap u_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_accept),
    .hue_i   (in_hue),
    .sat_i   (in_saturation),
    .val_i   (in_brightness),
    .valid_o (wrap_vld),
    .pix_o   (wrap_pix)
  );

  // Chroma, ramp and offset.
  htr_chroma u_chroma (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (wrap_vld),
    .pix_i   (wrap_pix),
    .valid_o (chr_vld),
    .terms_o (terms)
  );

  // Place chroma and ramp into channels by sector, then add the offset.
  always_comb begin
    case (terms.sector)
      SEC_R_TO_Y: begin
        r_term = terms.chroma; g_term = terms.ramp;   b_term = '0;
      end
      SEC_Y_TO_G: begin
        r_term = terms.ramp;   g_term = terms.chroma; b_term = '0;
      end
      SEC_G_TO_C: begin
        r_term = '0;           g_term = terms.chroma; b_term = terms.ramp;
      end
      SEC_C_TO_B: begin
        r_term = '0;           g_term = terms.ramp;   b_term = terms.chroma;
      end
      SEC_B_TO_M: begin
        r_term = terms.ramp;   g_term = '0;           b_term = terms.chroma;
      end
      default: begin
        r_term = terms.chroma; g_term = '0;           b_term = terms.ramp;
      end
    endcase
    r_sum_nxt = r_term + terms.offset;
    g_sum_nxt = g_term + terms.offset;
    b_sum_nxt = b_term + terms.offset;
  end

  // Selection stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= chr_vld;
    end
  end

  // Selection stage payload.
  always_ff @(posedge clk) begin
    r_sum_r <= r_sum_nxt;
    g_sum_r <= g_sum_nxt;
    b_sum_r <= b_sum_nxt;
  end

  // One divider per channel.
  htr_div_denom u_div_r (
    .clk (clk), .rst_n (rst_n), .valid_i (sum_vld_r), .num_i (r_sum_r),
    .valid_o (r_vld), .quot_o (out_red)
  );

  htr_div_denom u_div_g (
    .clk (clk), .rst_n (rst_n), .valid_i (sum_vld_r), .num_i (g_sum_r),
    .valid_o (g_vld), .quot_o (out_green)
  );

  htr_div_denom u_div_b (
    .clk (clk), .rst_n (rst_n), .valid_i (sum_vld_r), .num_i (b_sum_r),
    .valid_o (b_vld), .quot_o (out_blue)
  );

  assign out_valid = r_vld;

  `HTR_ASSERT(a_latency, clk, rst_n, out_valid |-> $past(in_accept, LATENCY), "result without a start")
  `HTR_ASSERT_ALWAYS(a_lanes_aligned, clk, (r_vld === g_vld) && (g_vld === b_vld), "lanes out of step")

endmodule

/* bench/hsv_to_rgb_converter_test.sv */
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
// Depends on htr_pkg and the hsv_to_rgb_converter RTL; reads no files.
module hsv_to_rgb_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import htr_pkg::*;

  localparam int RANDOM_PIXELS   = 500;
  localparam int STALL_LIMIT     = 200;
  localparam int DIRECTED_PIXELS = 25;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // One stimulus row; when known is set, rgb holds the hand-derived color.
  typedef struct packed {
    logic signed [IN_W-1:0] hue;
    logic signed [IN_W-1:0] sat;
    logic signed [IN_W-1:0] val;
    logic                   known;
    rgb_t                   rgb;
  } stim_row_t;

  // Directed rows: primaries and secondaries, hue wrapping, clamping, extremes.
  localparam stim_row_t DIRECTED [DIRECTED_PIXELS] = '{
    '{0,      255,    255,    1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{60,     255,    255,    1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{120,    255,    255,    1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{180,    255,    255,    1'b1, '{8'd0,   8'd255, 8'd255}},
    '{240,    255,    255,    1'b1, '{8'd0,   8'd0,   8'd255}},
    '{300,    255,    255,    1'b1, '{8'd255, 8'd0,   8'd255}},
    '{360,    255,    255,    1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{-120,   255,    255,    1'b1, '{8'd0,   8'd0,   8'd255}},
    '{-360,   255,    255,    1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{0,      0,      255,    1'b1, '{8'd255, 8'd255, 8'd255}},
    '{77,     -1,     200,    1'b1, '{8'd200, 8'd200, 8'd200}},
    '{200,    -32768, 128,    1'b1, '{8'd128, 8'd128, 8'd128}},
    '{0,      32767,  255,    1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{120,    256,    255,    1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{90,     255,    0,      1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{-32768, 255,    -32768, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{240,    255,    32767,  1'b1, '{8'd0,   8'd0,   8'd255}},
    '{30,     255,    255,    1'b0, '0},
    '{359,    255,    255,    1'b0, '0},
    '{32767,  255,    255,    1'b0, '0},
    '{-32768, 200,    180,    1'b0, '0},
    '{-1,     128,    255,    1'b0, '0},
    '{200,    100,    256,    1'b0, '0},
    '{45,     1,      1,      1'b0, '0},
    '{7,      128,    77,     1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] in_hue;
  logic signed [IN_W-1:0] in_saturation;
  logic signed [IN_W-1:0] in_brightness;
  logic                   out_valid;
  logic [CH_W-1:0]        out_red;
  logic [CH_W-1:0]        out_green;
  logic [CH_W-1:0]        out_blue;

  rgb_t rgb_due [$];
  int   burst_left      = 0;
  int   pixels_sent     = 0;
  int   results_checked = 0;
  int   error_count     = 0;
  int   quiet_cycles    = 0;

  hsv_to_rgb_converter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact integer conversion, every term scaled by 255*60 so that the
  // final divide is the only truncation.
  function automatic rgb_t hsv_pixel_to_rgb(logic signed [IN_W-1:0] hue,
                                            logic signed [IN_W-1:0] sat,
                                            logic signed [IN_W-1:0] val);
    int      angle;
    int      s;
    int      v;
    int      half;
    int      hdist;
    int      chroma;
    int      ramp;
    int      base;
    int      chan [3];
    sector_t sector;
    rgb_t    color;
    angle = int'(hue) % HUE_CIRCLE;
    if (angle < 0) begin
      angle += HUE_CIRCLE;
    end
    s = (sat < 0) ? 0 : (sat > FULL_SCALE) ? FULL_SCALE : int'(sat);
    v = (val < 0) ? 0 : (val > FULL_SCALE) ? FULL_SCALE : int'(val);
    half = angle % (2 * SECTOR_DEG);
    hdist = (half >= SECTOR_DEG) ? half - SECTOR_DEG : SECTOR_DEG - half;
    chroma = v * s * SECTOR_DEG;
    ramp   = v * s * (SECTOR_DEG - hdist);
    base   = v * DENOM - chroma;
    sector = sector_t'(angle / SECTOR_DEG);
    case (sector)
      SEC_R_TO_Y: chan = '{chroma, ramp, 0};
      SEC_Y_TO_G: chan = '{ramp, chroma, 0};
      SEC_G_TO_C: chan = '{0, chroma, ramp};
      SEC_C_TO_B: chan = '{0, ramp, chroma};
      SEC_B_TO_M: chan = '{ramp, 0, chroma};
      default:    chan = '{chroma, 0, ramp};
    endcase
    color.red   = CH_W'((chan[0] + base) / DENOM);
    color.green = CH_W'((chan[1] + base) / DENOM);
    color.blue  = CH_W'((chan[2] + base) / DENOM);
    return color;
  endfunction

  function automatic void check_channel(string name, logic [CH_W-1:0] want,
                                        logic [CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Sends one pixel transaction. The sender works in bursts; a new burst
  // may open with an idle gap.
  task automatic send_pixel(input stim_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_hue        <= row.hue;
    in_saturation <= row.sat;
    in_brightness <= row.val;
    do @(posedge clk); while (busy !== 1'b0);
    burst_left--;
    rgb_due.push_back(row.known ? row.rgb : hsv_pixel_to_rgb(row.hue, row.sat, row.val));
    pixels_sent++;
  endtask

  // Stimulus: reset, directed table, then random pixels, then drain.
  initial begin
    stim_row_t row;
    int        mode;
    int        h;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_PIXELS; i++) begin
      send_pixel(DIRECTED[i]);
    end

    // Mostly in-range pixels, some on sector boundaries, some clamped,
    // and a share of full-width noise so that every input bit toggles.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      mode      = $urandom_range(0, 9);
      row.known = 1'b0;
      row.rgb   = '0;
      if (mode < 2) begin
        row.hue = IN_W'($urandom);
        row.sat = IN_W'($urandom);
        row.val = IN_W'($urandom);
      end else begin
        h = (mode == 2) ? SECTOR_DEG * (int'($urandom_range(0, 24)) - 12)
                        : int'($urandom_range(0, 1440)) - 720;
        row.hue = IN_W'(h);
        row.sat = (mode == 3) ? IN_W'(int'($urandom_range(0, 340)) - 40)
                              : IN_W'($urandom_range(0, FULL_SCALE));
        row.val = (mode == 4) ? IN_W'(int'($urandom_range(0, 340)) - 40)
                              : IN_W'($urandom_range(0, FULL_SCALE));
      end
      send_pixel(row);
    end
    start <= 1'b0;

    while (rgb_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Converted %0d pixels (%0d directed, %0d random); %0d results compared.",
             pixels_sent, DIRECTED_PIXELS, RANDOM_PIXELS, results_checked);
    $display("Field mismatches or unexpected results: %0d.", error_count);
    if (error_count == 0 && rgb_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result checker: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (rgb_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                 $time, out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = rgb_due.pop_front();
        results_checked++;
        check_channel("red", want.red, out_red);
        check_channel("green", want.green, out_green);
        check_channel("blue", want.blue, out_blue);
      end
    end else if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
      error_count++;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/htr_pkg.sv
rtl/htr_hue_wrap.sv
rtl/htr_chroma.sv
rtl/htr_div_denom.sv
rtl/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_converter_test.sv
